// ===== sv/datediff_pkg.sv =====
// Package for the date difference core: payload structs, controller/datapath
// command and status structs, and the Gregorian calendar helper functions.
// No dependencies.
`default_nettype none

package datediff_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned CountW = 17;

  localparam logic [YearW-1:0]  YearMin  = YearW'(1900);
  localparam logic [YearW-1:0]  YearMax  = YearW'(2100);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   end_day;
    logic [MonthW-1:0] end_month;
    logic [YearW-1:0]  end_year;
  } date_pair_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              date_error;
  } day_result_t;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic date_err;
    logic start_lt_end;
  } dp_sts_t;

  // valid for 1900..2100 only: 1900 and 2100 are the century years that are not leap
  function automatic logic is_leap(input logic [YearW-1:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != YearMin) && (y != YearMax);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic [YearW-1:0] y);
    case (m)
      MonthFeb:                            month_len = is_leap(y) ? DayW'(29) : DayW'(28);
      MonthW'(4), MonthW'(6),
      MonthW'(9), MonthW'(11):             month_len = DayW'(30);
      default:                             month_len = DayW'(31);
    endcase
  endfunction

  function automatic logic date_ok(input logic [DayW-1:0] d,
                                   input logic [MonthW-1:0] m,
                                   input logic [YearW-1:0] y);
    date_ok = (y >= YearMin) && (y <= YearMax) &&
              (m >= MonthW'(1)) && (m <= MonthDec) &&
              (d >= DayW'(1)) && (d <= month_len(m, y));
  endfunction

endpackage

`default_nettype wire

// ===== sv/date_difference_in_days_core.sv =====
// Top level of the Gregorian date difference core: joins controller and
// datapath. Depends on datediff_pkg, datediff_ctrl, datediff_dp.
//
//   channel   ports                              payload
//   input     in_valid / in_ready / in_data      date_pair_t
//   result    out_valid / out_ready / out_data   day_result_t
//   config    cfg_wr_en / cfg_wr_data            count_end_day bit
//
// One item at a time: a load, a date check, day stepping (one day per cycle)
// until the end date is reached, then a publish. Invalid dates skip stepping.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits to publish.
// rst_n is synchronous; it clears control state and the config bit.
`default_nettype none

module date_difference_in_days_core import datediff_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire date_pair_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output day_result_t      out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  datediff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  datediff_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/datediff_dp.sv =====
// Datapath of the date difference core: date registers, day stepper,
// step counter, end-day config bit and output payload register. Uses datediff_pkg.
`default_nettype none

module datediff_dp import datediff_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire date_pair_t  in_data,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  output day_result_t      out_data
);

  logic              count_end_day_r;
  logic [DayW-1:0]   cur_day_r,   cur_day_nxt;
  logic [MonthW-1:0] cur_month_r, cur_month_nxt;
  logic [YearW-1:0]  cur_year_r,  cur_year_nxt;
  logic [DayW-1:0]   end_day_r;
  logic [MonthW-1:0] end_month_r;
  logic [YearW-1:0]  end_year_r;
  logic [CountW-1:0] count_r;
  logic              err_r;
  day_result_t       out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_end_day_r <= 1'b0;
    end else if (cfg_wr_en) begin
      count_end_day_r <= cfg_wr_data;
    end
  end

  assign sts.date_err = !(date_ok(cur_day_r, cur_month_r, cur_year_r) &&
                          date_ok(end_day_r, end_month_r, end_year_r));
  assign sts.start_lt_end = {cur_year_r, cur_month_r, cur_day_r} <
                            {end_year_r, end_month_r, end_day_r};

  always_comb begin
    cur_day_nxt   = cur_day_r + DayW'(1);
    cur_month_nxt = cur_month_r;
    cur_year_nxt  = cur_year_r;
    if (cur_day_r == month_len(cur_month_r, cur_year_r)) begin
      cur_day_nxt = DayW'(1);
      if (cur_month_r == MonthDec) begin
        cur_month_nxt = MonthW'(1);
        cur_year_nxt  = cur_year_r + YearW'(1);
      end else begin
        cur_month_nxt = cur_month_r + MonthW'(1);
      end
    end
  end

  always_comb begin
    out_nxt.date_error = err_r;
    out_nxt.day_count  = err_r ? '0 : count_r + CountW'(count_end_day_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_day_r   <= in_data.start_day;
      cur_month_r <= in_data.start_month;
      cur_year_r  <= in_data.start_year;
      end_day_r   <= in_data.end_day;
      end_month_r <= in_data.end_month;
      end_year_r  <= in_data.end_year;
      count_r     <= '0;
    end else if (cmd.step) begin
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
      count_r     <= count_r + CountW'(1);
    end
    if (cmd.check) begin
      err_r <= sts.date_err;
    end
    if (cmd.publish) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== sv/datediff_ctrl.sv =====
// Controller of the date difference core: sequences load, date check,
// day stepping and output transfer. Uses datediff_pkg.
`default_nettype none

module datediff_ctrl import datediff_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_STEP   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.date_err ? ST_FINISH : ST_STEP;
      end
      ST_STEP: begin
        if (sts.start_lt_end) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_CHECK)
    else $error("accepted transfer did not enter date check");

  a_step_only_before_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> sts.start_lt_end && state_r == ST_STEP)
    else $error("day advanced past end date");

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r && state_r == ST_IDLE)
    else $error("publish did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
